// ===== rtl/fgcc_pkg.sv =====
package fgcc_pkg;

	localparam int DEF_MAP_ROWS  = 256;
	localparam int DEF_MAP_COLS  = 256;
	localparam int DEF_MAX_STEPS = 256;

	localparam int CELL_AW    = 16;
	localparam int CELL_DEPTH = 1 << CELL_AW;
	localparam logic [7:0] OBSTACLE = 8'd127;
	localparam int SLACK_Q16 = 66;

	localparam int ANG_W       = 22;
	localparam int ANG_PI      = 205887;
	localparam int ANG_HALF_PI = 102944;
	localparam int ANG_TWO_PI  = 411775;

	localparam int VEC_W    = 34;
	localparam int CORDIC_K = 652032874;
	localparam int CORDIC_N = 16;
	localparam int TRIG_W   = 18;

	localparam int CX_W   = 24;
	localparam int MA_W   = 34;
	localparam int MB_W   = 18;
	localparam int ACC_W  = 54;
	localparam int POS_W  = 40;
	localparam int NUM_W  = 44;
	localparam int DEN_W  = 24;
	localparam int RES_W  = 21;
	localparam int REACH_W = 20;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	localparam int IN_TDATA_W  = 112;
	localparam int OUT_TDATA_W = 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_ORIGIN_X   = 3'd0;
	localparam cfg_idx_t CFG_ORIGIN_Y   = 3'd1;
	localparam cfg_idx_t CFG_ORIGIN_YAW = 3'd2;
	localparam cfg_idx_t CFG_CELL_SIZE  = 3'd3;
	localparam cfg_idx_t CFG_REAR       = 3'd4;
	localparam cfg_idx_t CFG_FRONT      = 3'd5;
	localparam cfg_idx_t CFG_HALF_WIDTH = 3'd6;

	localparam logic [RES_W-1:0]   DEF_CELL_SIZE  = 21'd3277;
	localparam logic [REACH_W-1:0] DEF_REAR       = 20'd45875;
	localparam logic [REACH_W-1:0] DEF_FRONT      = 20'd216269;
	localparam logic [REACH_W-1:0] DEF_HALF_WIDTH = 20'd72090;

	typedef struct packed {
		logic                is_check;
		logic [15:0]         cell_index;
		logic [7:0]          cell_value;
		logic signed [31:0]  pose_x;
		logic signed [31:0]  pose_y;
		logic signed [19:0]  pose_yaw;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	function automatic logic signed [ANG_W-1:0] atan_entry(input logic [3:0] i);
		logic signed [ANG_W-1:0] v;
		case (i)
			4'd0:    v = 22'sd51472;
			4'd1:    v = 22'sd30386;
			4'd2:    v = 22'sd16055;
			4'd3:    v = 22'sd8150;
			4'd4:    v = 22'sd4091;
			4'd5:    v = 22'sd2047;
			4'd6:    v = 22'sd1024;
			4'd7:    v = 22'sd512;
			4'd8:    v = 22'sd256;
			4'd9:    v = 22'sd128;
			4'd10:   v = 22'sd64;
			4'd11:   v = 22'sd32;
			4'd12:   v = 22'sd16;
			4'd13:   v = 22'sd8;
			4'd14:   v = 22'sd4;
			default: v = 22'sd2;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/fgcc_front.sv =====
module fgcc_front import fgcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,
	input  logic                  s_tuser,
	input  logic                  pop,
	output q_head_t               head
);

	item_t              buf_q [Q_DEPTH];
	logic [Q_AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]      cnt_q;
	logic               push, pull;
	item_t              in_item;

	always_comb begin
		in_item.is_check   = s_tuser;
		in_item.cell_index = s_tdata[15:0];
		in_item.cell_value = s_tdata[23:16];
		in_item.pose_x     = s_tdata[55:24];
		in_item.pose_y     = s_tdata[87:56];
		in_item.pose_yaw   = s_tdata[107:88];
	end

	assign s_tready   = (cnt_q != (Q_AW+1)'(Q_DEPTH));
	assign push       = s_tvalid && s_tready;
	assign pull       = pop && (cnt_q != '0);
	assign head.valid = (cnt_q != '0);
	assign head.item  = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pull) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pull})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/fgcc_div.sv =====
module fgcc_div import fgcc_pkg::*; #(
	parameter int QB = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DEN_W+QB-1:0]   num,
	input  logic [DEN_W-1:0]      den,
	output logic                  done,
	output logic [QB-1:0]         quo
);

	localparam int CNT_W = $clog2(QB + 1);

	logic [DEN_W+QB-1:0] rem_q, dsh_q;
	logic [QB-1:0]       quo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                done_q;
	logic                ge;

	assign ge   = (rem_q >= dsh_q);
	assign done = done_q;
	assign quo  = quo_q;

	// one quotient bit a cycle, most significant first
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= (DEN_W+QB)'(den) << (QB - 1);
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QB-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(QB);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/fgcc_back.sv =====
module fgcc_back import fgcc_pkg::*; #(
	parameter int MAP_ROWS           = DEF_MAP_ROWS,
	parameter int MAP_COLS           = DEF_MAP_COLS,
	parameter int MAX_STEPS_PER_AXIS = DEF_MAX_STEPS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  cfg_idx_t               cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  q_head_t                head,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tuser
);

	localparam int DIM_MAX = (MAP_ROWS > MAP_COLS) ? MAP_ROWS : MAP_COLS;
	localparam int QB      = $clog2(DIM_MAX);
	localparam int STEP_W  = $clog2(MAX_STEPS_PER_AXIS + 1);

	typedef enum logic [4:0] {
		ST_IDLE, ST_WRAP, ST_FOLD, ST_ROT, ST_TFIN,
		ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6,
		ST_YTEST, ST_XTEST,
		ST_S0, ST_S1, ST_S2, ST_S3, ST_S4, ST_S5,
		ST_DSET, ST_DWAIT, ST_DCHK, ST_R0, ST_R1, ST_ADV, ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic signed [31:0]  ox_q, oy_q;
	logic signed [19:0]  oyaw_q;
	logic [RES_W-1:0]    res_raw_q;
	logic [REACH_W-1:0]  rear_q, front_q, hw_q;
	logic [RES_W-1:0]    res;

	// datapath
	logic signed [32:0]        dx_q, dy_q;
	logic signed [19:0]        pyaw_q;
	logic signed [ANG_W-1:0]   ang_q;
	logic                      neg_q, phase_q, axis_q;
	logic signed [VEC_W-1:0]   vx_q, vy_q;
	logic [3:0]                it_q;
	logic signed [TRIG_W-1:0]  c_q, s_q, cl_q, sl_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [POS_W-1:0]   zlx_q, zly_q, resr_q, resc_q, xs_q, ys_q;
	logic signed [NUM_W-1:0]   nr_q, nc_q;
	logic signed [CX_W-1:0]    cx_q, cy_q;
	logic [STEP_W-1:0]         nx_q, ny_q;
	logic [QB-1:0]             dq_q, row_q, col_q;
	logic [7:0]                rd_q;
	logic [7:0]                mem [CELL_DEPTH];

	logic                      out_valid_q, out_check_q, out_coll_q;

	// combinational helpers
	logic signed [MA_W-1:0]    mul_a;
	logic signed [MB_W-1:0]    mul_b;
	logic signed [ACC_W-1:0]   prod, acc_sh;
	logic signed [VEC_W-1:0]   xsh, ysh, xr, yr;
	logic signed [TRIG_W-1:0]  cos_v, sin_v;
	logic                      ang_hi, ang_lo;
	logic signed [CX_W-1:0]    x_lim, y_lim;
	logic                      x_go, y_go;
	logic signed [NUM_W-1:0]   nsel;
	logic [NUM_W-1:0]          nmag;
	logic [DEN_W-1:0]          dsel;
	logic                      n_neg, n_small, n_big;
	logic                      div_start, div_done;
	logic [QB-1:0]             div_q;
	logic                      dq_in;
	logic [31:0]               idx_full;
	logic [CELL_AW-1:0]        rd_addr;
	logic                      wr_item;

	assign res = (res_raw_q == '0) ? RES_W'(1) : res_raw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q      <= '0;
			oy_q      <= '0;
			oyaw_q    <= '0;
			res_raw_q <= DEF_CELL_SIZE;
			rear_q    <= DEF_REAR;
			front_q   <= DEF_FRONT;
			hw_q      <= DEF_HALF_WIDTH;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ORIGIN_X:   ox_q      <= cfg_data;
				CFG_ORIGIN_Y:   oy_q      <= cfg_data;
				CFG_ORIGIN_YAW: oyaw_q    <= cfg_data[19:0];
				CFG_CELL_SIZE:  res_raw_q <= cfg_data[RES_W-1:0];
				CFG_REAR:       rear_q    <= cfg_data[REACH_W-1:0];
				CFG_FRONT:      front_q   <= cfg_data[REACH_W-1:0];
				CFG_HALF_WIDTH: hw_q      <= cfg_data[REACH_W-1:0];
				default: ;
			endcase
		end
	end

	assign pop     = (state_q == ST_IDLE) && head.valid && (!out_valid_q || m_tready);
	assign wr_item = pop && !head.item.is_check;

	// shared multiplier
	always_comb begin
		case (state_q)
			ST_M0:   begin mul_a = MA_W'(dx_q); mul_b = c_q; end
			ST_M1:   begin mul_a = MA_W'(dy_q); mul_b = s_q; end
			ST_M2:   begin mul_a = MA_W'(dy_q); mul_b = c_q; end
			ST_M3:   begin mul_a = MA_W'(dx_q); mul_b = s_q; end
			ST_M4:   begin mul_a = MA_W'(res);  mul_b = MB_W'(MAP_ROWS); end
			ST_M5:   begin mul_a = MA_W'(res);  mul_b = MB_W'(MAP_COLS); end
			ST_S0:   begin mul_a = MA_W'(cx_q); mul_b = cl_q; end
			ST_S1:   begin mul_a = MA_W'(cy_q); mul_b = sl_q; end
			ST_S2:   begin mul_a = MA_W'(cy_q); mul_b = cl_q; end
			ST_S3:   begin mul_a = MA_W'(cx_q); mul_b = sl_q; end
			default: begin mul_a = '0;          mul_b = '0; end
		endcase
	end

	assign prod   = mul_a * mul_b;
	assign acc_sh = acc_q >>> 16;

	assign xsh    = vx_q >>> it_q;
	assign ysh    = vy_q >>> it_q;
	assign xr     = (vx_q + VEC_W'(8192)) >>> 14;
	assign yr     = (vy_q + VEC_W'(8192)) >>> 14;
	assign cos_v  = neg_q ? -xr[TRIG_W-1:0] : xr[TRIG_W-1:0];
	assign sin_v  = neg_q ? -yr[TRIG_W-1:0] : yr[TRIG_W-1:0];

	assign ang_hi = (ang_q > ANG_W'(ANG_PI));
	assign ang_lo = (ang_q < -ANG_W'(ANG_PI));

	assign x_lim  = CX_W'(front_q) + CX_W'(SLACK_Q16);
	assign y_lim  = CX_W'(hw_q) + CX_W'(SLACK_Q16);
	assign x_go   = (cx_q < x_lim) && (nx_q < STEP_W'(MAX_STEPS_PER_AXIS));
	assign y_go   = (cy_q < y_lim) && (ny_q < STEP_W'(MAX_STEPS_PER_AXIS));

	// row numerator over 4*res, column numerator over 2*res
	assign nsel    = axis_q ? nc_q : nr_q;
	assign dsel    = axis_q ? (DEN_W'(res) << 1) : (DEN_W'(res) << 2);
	assign n_neg   = nsel[NUM_W-1];
	assign nmag    = -nsel;
	assign n_small = (nmag < NUM_W'(dsel));
	assign n_big   = (nsel >= (NUM_W'(dsel) << QB));
	assign div_start = (state_q == ST_DSET) && !n_neg && !n_big;
	assign dq_in   = axis_q ? (32'(dq_q) < 32'(MAP_COLS)) : (32'(dq_q) < 32'(MAP_ROWS));

	fgcc_div #(.QB(QB)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (nsel[DEN_W+QB-1:0]),
		.den    (dsel),
		.done   (div_done),
		.quo    (div_q)
	);

	assign idx_full = 32'(row_q) * 32'(MAP_COLS) + 32'(col_q);
	assign rd_addr  = idx_full[CELL_AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_item) begin
			mem[head.item.cell_index] <= head.item.cell_value;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dx_q    <= 33'(head.item.pose_x) - 33'(ox_q);
				dy_q    <= 33'(head.item.pose_y) - 33'(oy_q);
				pyaw_q  <= head.item.pose_yaw;
				ang_q   <= ANG_W'(oyaw_q);
				phase_q <= 1'b0;
			end
			ST_WRAP: begin
				if (ang_hi) begin
					ang_q <= ang_q - ANG_W'(ANG_TWO_PI);
				end else if (ang_lo) begin
					ang_q <= ang_q + ANG_W'(ANG_TWO_PI);
				end
			end
			ST_FOLD: begin
				if (ang_q > ANG_W'(ANG_HALF_PI)) begin
					ang_q <= ang_q - ANG_W'(ANG_PI);
					neg_q <= 1'b1;
				end else if (ang_q < -ANG_W'(ANG_HALF_PI)) begin
					ang_q <= ang_q + ANG_W'(ANG_PI);
					neg_q <= 1'b1;
				end else begin
					neg_q <= 1'b0;
				end
				vx_q <= VEC_W'(CORDIC_K);
				vy_q <= '0;
				it_q <= '0;
			end
			ST_ROT: begin
				if (ang_q >= 0) begin
					vx_q  <= vx_q - ysh;
					vy_q  <= vy_q + xsh;
					ang_q <= ang_q - atan_entry(it_q);
				end else begin
					vx_q  <= vx_q + ysh;
					vy_q  <= vy_q - xsh;
					ang_q <= ang_q + atan_entry(it_q);
				end
				it_q <= it_q + 1'b1;
			end
			ST_TFIN: begin
				if (phase_q) begin
					cl_q <= cos_v;
					sl_q <= sin_v;
				end else begin
					c_q <= cos_v;
					s_q <= sin_v;
				end
				cy_q <= -CX_W'(hw_q);
				ny_q <= '0;
			end
			ST_M0: acc_q <= prod;
			ST_M1: acc_q <= acc_q + prod;
			ST_M2: begin
				zlx_q <= acc_sh[POS_W-1:0];
				acc_q <= prod;
			end
			ST_M3: acc_q <= acc_q - prod;
			ST_M4: begin
				zly_q <= acc_sh[POS_W-1:0];
				acc_q <= prod;
			end
			ST_M5: begin
				resr_q <= acc_q[POS_W-1:0];
				acc_q  <= prod;
			end
			ST_M6: begin
				resc_q  <= acc_q[POS_W-1:0];
				ang_q   <= ANG_W'(pyaw_q) - ANG_W'(oyaw_q);
				phase_q <= 1'b1;
			end
			ST_YTEST: begin
				cx_q <= -CX_W'(rear_q);
				nx_q <= '0;
			end
			ST_XTEST: begin
				if (!x_go) begin
					cy_q <= cy_q + CX_W'(res);
					ny_q <= ny_q + 1'b1;
				end
			end
			ST_S0: acc_q <= prod;
			ST_S1: acc_q <= acc_q + prod;
			ST_S2: begin
				xs_q  <= zlx_q + acc_sh[POS_W-1:0];
				acc_q <= prod;
			end
			ST_S3: acc_q <= acc_q - prod;
			ST_S4: ys_q <= zly_q + acc_sh[POS_W-1:0];
			ST_S5: begin
				nr_q   <= (NUM_W'(xs_q) <<< 2) + NUM_W'(resr_q);
				nc_q   <= NUM_W'(resc_q) - (NUM_W'(ys_q) <<< 1);
				axis_q <= 1'b0;
			end
			ST_DSET: begin
				// a numerator just below zero still truncates to cell zero
				dq_q <= '0;
			end
			ST_DWAIT: begin
				if (div_done) begin
					dq_q <= div_q;
				end
			end
			ST_DCHK: begin
				if (dq_in) begin
					if (axis_q) begin
						col_q <= dq_q;
					end else begin
						row_q  <= dq_q;
						axis_q <= 1'b1;
					end
				end
			end
			ST_ADV: begin
				cx_q <= cx_q + CX_W'(res);
				nx_q <= nx_q + 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_check_q <= 1'b0;
			out_coll_q  <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.item.is_check) begin
							state_q <= ST_WRAP;
						end else begin
							out_valid_q <= 1'b1;
							out_check_q <= 1'b0;
							out_coll_q  <= 1'b0;
						end
					end
				end
				ST_WRAP:  if (!ang_hi && !ang_lo) state_q <= ST_FOLD;
				ST_FOLD:  state_q <= ST_ROT;
				ST_ROT:   if (it_q == 4'(CORDIC_N - 1)) state_q <= ST_TFIN;
				ST_TFIN:  state_q <= phase_q ? ST_YTEST : ST_M0;
				ST_M0:    state_q <= ST_M1;
				ST_M1:    state_q <= ST_M2;
				ST_M2:    state_q <= ST_M3;
				ST_M3:    state_q <= ST_M4;
				ST_M4:    state_q <= ST_M5;
				ST_M5:    state_q <= ST_M6;
				ST_M6:    state_q <= ST_WRAP;
				ST_YTEST: begin
					if (y_go) begin
						state_q <= ST_XTEST;
					end else begin
						out_coll_q <= 1'b0;
						state_q    <= ST_DONE;
					end
				end
				ST_XTEST: state_q <= x_go ? ST_S0 : ST_YTEST;
				ST_S0:    state_q <= ST_S1;
				ST_S1:    state_q <= ST_S2;
				ST_S2:    state_q <= ST_S3;
				ST_S3:    state_q <= ST_S4;
				ST_S4:    state_q <= ST_S5;
				ST_S5:    state_q <= ST_DSET;
				ST_DSET: begin
					if (n_neg) begin
						state_q <= n_small ? ST_DCHK : ST_ADV;
					end else if (n_big) begin
						state_q <= ST_ADV;
					end else begin
						state_q <= ST_DWAIT;
					end
				end
				ST_DWAIT: if (div_done) state_q <= ST_DCHK;
				ST_DCHK: begin
					if (!dq_in) begin
						state_q <= ST_ADV;
					end else begin
						state_q <= axis_q ? ST_R0 : ST_DSET;
					end
				end
				ST_R0:    state_q <= ST_R1;
				ST_R1: begin
					if (rd_q == OBSTACLE) begin
						out_coll_q <= 1'b1;
						state_q    <= ST_DONE;
					end else begin
						state_q <= ST_ADV;
					end
				end
				ST_ADV:   state_q <= ST_XTEST;
				ST_DONE: begin
					out_valid_q <= 1'b1;
					out_check_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_check_q;
	assign m_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_coll_q};

endmodule

// ===== rtl/footprint_grid_collision_check.sv =====
// Footprint collision check against a byte occupancy grid.
// Input stream s_*: tuser 0 writes one grid cell, tuser 1 checks one pose.
// Output stream m_*: one transaction per input transaction, in order;
// tuser echoes the kind, tdata[0] flags a collision (always 0 for writes).
// Configuration channel cfg_*: index and data, taken every cycle; write it
// only while no transaction is in flight.
// A four-entry queue lets the input side take transactions while the
// checker works. A cell write goes into the grid as it leaves the queue.
// A check first sets up with two 16-step CORDIC passes and the frame
// transform on one shared multiplier, then maps each footprint sample to
// a row and a column with the bit-serial divider. It stops at the first
// obstacle cell.
// Reset empties the queue and the output register and restores the
// register defaults; grid contents stay undefined until written.
// While the receiver holds m_tready low the result waits in the output
// register and the queue keeps filling until s_tready falls.
module footprint_grid_collision_check import fgcc_pkg::*; #(
	parameter int MAP_ROWS           = DEF_MAP_ROWS,
	parameter int MAP_COLS           = DEF_MAP_COLS,
	parameter int MAX_STEPS_PER_AXIS = DEF_MAX_STEPS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// cell_index[15:0], cell_value[23:16], pose_x[55:24], pose_y[87:56],
	// pose_yaw[107:88], zero [111:108]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// func
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// collides[0], zero [7:1]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// was_check
	output logic                   m_tuser,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  cfg_idx_t               cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	q_head_t head;
	logic    pop;

	assign cfg_ready = 1'b1;

	fgcc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.pop      (pop),
		.head     (head)
	);

	fgcc_back #(
		.MAP_ROWS           (MAP_ROWS),
		.MAP_COLS           (MAP_COLS),
		.MAX_STEPS_PER_AXIS (MAX_STEPS_PER_AXIS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// ===== rtl/fgcc_checker.sv =====
module fgcc_checker import fgcc_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser,
	input logic                   cfg_valid,
	input logic                   cfg_ready
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed or dropped");

	// a write acknowledgement never reports a collision
	a_write_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[0] == 1'b0)
		else $error("write acknowledgement flags a collision");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:1] == '0)
		else $error("padding bits of result not zero");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind footprint_grid_collision_check fgcc_checker u_fgcc_checker (.*);
